### rtl/core/glmf_pkg.sv
// Shared types and constants of the grid local maximum finder.
// Used by glmf_result_fifo and grid_local_maximum_finder; depends on nothing.
package glmf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_SAMPLE_BITS = 32;

    // Fixed field widths of the configuration and result ports.
    localparam int CFG_W      = 11;
    localparam int POS_W      = 11;
    localparam int TOTAL_W    = 21;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register values after reset.
    localparam int RESET_NUM_ROWS = 1024;
    localparam int RESET_NUM_COLS = 1024;

    // The frame total saturates at all ones.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Result queue depth; one item pushes at most two results.
    localparam int RESULT_FIFO_DEPTH = 4;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } glmf_opcode_t;

    typedef enum logic {
        KIND_PEAK  = 1'b0,
        KIND_TOTAL = 1'b1
    } glmf_kind_t;

    typedef struct packed {
        glmf_kind_t          kind;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } glmf_result_t;

    // Results produced by one accepted item.
    typedef struct packed {
        logic peak;
        logic total;
    } glmf_push_t;

endpackage

### rtl/core/grid_local_maximum_finder.sv
// Top level of the streaming 4-neighbor local maximum finder.
// Depends on glmf_pkg, glmf_line_store and glmf_result_fifo.
//
// Usage: a frame of num_rows x num_cols signed samples enters in raster order
// on the s_ channel (opcode OP_SAMPLE), followed by num_cols flush beats
// (opcode OP_FLUSH) that decide the last row. Element (r, c) is decided when
// the sample below it arrives, so each sample beat reports the peak, if any,
// of the row above. Each peak leaves on the m_ channel as a beat with its
// 1-based row and column. The final flush beat also gives a total beat with
// the saturated peak count and last set; it follows that beat's peak, if any.
// Samples that arrive during flushing and flushes that arrive too early are
// taken and dropped. The APB port holds num_rows and num_cols (at 0x0 and
// 0x4); any write restarts the frame and must be made while the block is idle.
// Throughput is one beat per cycle while s_ready is high: the line store read
// for the next column is issued in the cycle that an item is accepted. Results
// enter the result queue when the causing beat is accepted. A four-entry result
// queue absorbs receiver stalls; s_ready drops while fewer than two entries are free.
// Reset restores 1024 x 1024 (clamped to the parameters) and restarts the
// frame. The line stores are not cleared and need no pass after reset.
module grid_local_maximum_finder import glmf_pkg::*; #(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [POS_W-1:0]              m_peak_row,
    output logic [POS_W-1:0]              m_peak_col,
    output logic [TOTAL_W-1:0]            m_peak_total,
    output logic                          m_last,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int RESET_EFF_ROWS = (RESET_NUM_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_NUM_ROWS;
    localparam int RESET_EFF_COLS = (RESET_NUM_COLS > MAX_COLS) ? MAX_COLS : RESET_NUM_COLS;

    // Configuration registers and their clamped working copies.
    logic [CFG_W-1:0]   num_rows_reg;
    logic [CFG_W-1:0]   num_cols_reg;
    logic [ROW_W-1:0]   eff_rows_reg;
    logic [COL_W-1:0]   eff_cols_reg;
    logic [CFG_W-1:0]   wr_val;
    logic [ROW_W-1:0]   eff_rows_wr;
    logic [COL_W-1:0]   eff_cols_wr;
    logic               cfg_wr;

    // Frame position, peak count and the left neighbor of the element in work.
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [IDX_W-1:0]   col_reg;
    logic [IDX_W-1:0]   col_next;
    logic [TOTAL_W-1:0] peak_count_reg;
    logic [TOTAL_W-1:0] peak_count_next;
    logic [TOTAL_W-1:0] count_plus;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] left_next;

    // Line store read data for the current column.
    logic signed [SAMPLE_BITS-1:0] self_rd;
    logic signed [SAMPLE_BITS-1:0] right_rd;
    logic signed [SAMPLE_BITS-1:0] above_rd;

    logic               accept;
    logic               is_flush;
    logic               in_frame;
    logic               do_sample;
    logic               do_flush;
    logic               decide;
    logic [COL_W-1:0]   col_plus1;
    logic               has_left;
    logic               has_right;
    logic               chk_above;
    logic               chk_below;
    logic               peak_hit;
    logic               frame_done;
    logic               has_room;

    glmf_push_t         push;
    glmf_result_t       peak_item;
    glmf_result_t       total_item;
    glmf_result_t       out_item;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so every access completes without wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_val = pwdata[CFG_W-1:0];
    assign prdata = (paddr[2] == REG_NUM_COLS) ? APB_DATA_W'(num_cols_reg)
                                               : APB_DATA_W'(num_rows_reg);

    // A value of zero acts as one; a value above the maximum acts as the maximum.
    always_comb begin
        if (wr_val == '0) begin
            eff_rows_wr = ROW_W'(1);
            eff_cols_wr = COL_W'(1);
        end else begin
            eff_rows_wr = (32'(wr_val) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(wr_val);
            eff_cols_wr = (32'(wr_val) > 32'(MAX_COLS)) ? COL_W'(MAX_COLS) : COL_W'(wr_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= CFG_W'(RESET_NUM_ROWS);
            num_cols_reg <= CFG_W'(RESET_NUM_COLS);
            eff_rows_reg <= ROW_W'(RESET_EFF_ROWS);
            eff_cols_reg <= COL_W'(RESET_EFF_COLS);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NUM_COLS) begin
                num_cols_reg <= wr_val;
                eff_cols_reg <= eff_cols_wr;
            end else begin
                num_rows_reg <= wr_val;
                eff_rows_reg <= eff_rows_wr;
            end
        end
    end

    // ------------------------------------------------------------------
    // Decision. The element in work sits at column col_reg of the middle
    // line. During sampling the incoming sample is its lower neighbor; during
    // flushing the last row is decided with no lower neighbor.
    // ------------------------------------------------------------------
    assign accept    = s_valid && s_ready;
    assign is_flush  = (s_opcode == OP_FLUSH);
    assign in_frame  = row_reg < eff_rows_reg;
    assign do_sample = accept && !is_flush && in_frame;
    assign do_flush  = accept && is_flush && !in_frame;
    assign col_plus1 = COL_W'(col_reg) + COL_W'(1);
    assign has_left  = col_reg != '0;
    assign has_right = col_plus1 < eff_cols_reg;
    assign chk_below = !is_flush;
    assign chk_above = is_flush ? (eff_rows_reg > ROW_W'(1)) : (row_reg > ROW_W'(1));

    // Ties count as peaks, so only a strictly larger neighbor rules one out.
    assign peak_hit = !(chk_below && (self_rd < s_sample))
                   && !(chk_above && (self_rd < above_rd))
                   && !(has_left  && (self_rd < left_reg))
                   && !(has_right && (self_rd < right_rd));

    // The first row has nothing above it to decide yet.
    assign decide     = (do_sample && (row_reg != '0)) || do_flush;
    assign frame_done = do_flush && !has_right;

    assign push.peak  = decide && peak_hit;
    assign push.total = frame_done;

    assign count_plus = (push.peak && (peak_count_reg != TOTAL_MAX))
                      ? peak_count_reg + TOTAL_W'(1) : peak_count_reg;

    always_comb begin
        peak_item.kind  = KIND_PEAK;
        peak_item.row   = do_flush ? POS_W'(eff_rows_reg) : POS_W'(row_reg);
        peak_item.col   = POS_W'(col_plus1);
        peak_item.total = '0;
        peak_item.last  = 1'b0;

        total_item.kind  = KIND_TOTAL;
        total_item.row   = '0;
        total_item.col   = '0;
        total_item.total = count_plus;
        total_item.last  = 1'b1;
    end

    // ------------------------------------------------------------------
    // Position update. The column register doubles as the flush position,
    // since the column always wraps to zero after the last sample.
    // ------------------------------------------------------------------
    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        peak_count_next = peak_count_reg;
        left_next       = left_reg;
        if (cfg_wr) begin
            row_next        = '0;
            col_next        = '0;
            peak_count_next = '0;
        end else if (do_sample || do_flush) begin
            left_next       = self_rd;
            peak_count_next = count_plus;
            col_next        = has_right ? col_plus1[IDX_W-1:0] : '0;
            if (do_sample && !has_right) begin
                row_next = row_reg + ROW_W'(1);
            end
            if (frame_done) begin
                row_next        = '0;
                peak_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            peak_count_reg <= '0;
        end else begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            peak_count_reg <= peak_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg <= left_next;
    end

    // Reads are addressed by the next column so the neighbors are ready for
    // an item in the very next cycle.
    glmf_line_store #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_line_store (
        .aclk     (aclk),
        .wr_en    (do_sample),
        .wr_addr  (col_reg),
        .wr_mid   (s_sample),
        .wr_up    (self_rd),
        .rd_addr  (col_next),
        .self_rd  (self_rd),
        .right_rd (right_rd),
        .above_rd (above_rd)
    );

    glmf_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .peak_item  (peak_item),
        .total_item (total_item),
        .has_room   (has_room),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_item   (out_item)
    );

    assign s_ready      = has_room;
    assign m_kind       = out_item.kind;
    assign m_peak_row   = out_item.row;
    assign m_peak_col   = out_item.col;
    assign m_peak_total = out_item.total;
    assign m_last       = out_item.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= eff_rows_reg)
        else $error("row position beyond the frame");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        COL_W'(col_reg) < eff_cols_reg)
        else $error("column position beyond the row");

    a_no_count_in_first_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg == '0) |-> (peak_count_reg == '0))
        else $error("peaks counted before any element was decided");

    a_total_restarts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        push.total |=> ((row_reg == '0) && (col_reg == '0) && (peak_count_reg == '0)))
        else $error("frame did not restart after the total");

endmodule

### rtl/core/glmf_line_store.sv
// Two line stores (middle and upper row) with registered, write-forwarded reads.
// Standalone; instantiated by grid_local_maximum_finder.
module glmf_line_store #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 32,
    parameter int IDX_W       = 10
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_mid,
    input  logic signed [SAMPLE_BITS-1:0] wr_up,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic signed [SAMPLE_BITS-1:0] self_rd,
    output logic signed [SAMPLE_BITS-1:0] right_rd,
    output logic signed [SAMPLE_BITS-1:0] above_rd
);

    logic signed [SAMPLE_BITS-1:0] mid_line_reg [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] up_line_reg  [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] self_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic signed [SAMPLE_BITS-1:0] above_reg;
    logic [IDX_W-1:0]              right_addr;

    assign right_addr = rd_addr + IDX_W'(1);

    // A read of the entry written in the same cycle returns the new value.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mid_line_reg[wr_addr] <= wr_mid;
            up_line_reg[wr_addr]  <= wr_up;
        end
        self_reg  <= (wr_en && (wr_addr == rd_addr)) ? wr_mid : mid_line_reg[rd_addr];
        right_reg <= (wr_en && (wr_addr == right_addr)) ? wr_mid : mid_line_reg[right_addr];
        above_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_up : up_line_reg[rd_addr];
    end

    assign self_rd  = self_reg;
    assign right_rd = right_reg;
    assign above_rd = above_reg;

endmodule

### rtl/core/glmf_result_fifo.sv
// Small result queue between the decision logic and the result channel.
// Depends on glmf_pkg for the result and push types.
module glmf_result_fifo import glmf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  glmf_push_t   push,
    input  glmf_result_t peak_item,
    input  glmf_result_t total_item,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_ready,
    output glmf_result_t out_item
);

    localparam int DEPTH = RESULT_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    glmf_result_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] total_ptr;
    logic             pop;

    // Room for the worst case of two results from one item.
    assign has_room  = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        push_n      = CNT_W'(push.peak) + CNT_W'(push.total);
        total_ptr   = push.peak ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.peak) begin
            entry_reg[wr_ptr_reg] <= peak_item;
        end
        if (push.total) begin
            entry_reg[total_ptr] <= total_item;
        end
    end

endmodule
